### src/cld_pkg.sv
// Shared types and constants for the checked length frame deframer.
package cld_pkg;

    // Fixed field widths of the result channel and the config index
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Fixed-format sync bytes
    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd2;

    // Frame formats
    localparam logic MODE_CHECKED = 1'b0;
    localparam logic MODE_FIXED   = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_FRAMING = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_JUNK    = 3'd3,
        EV_HDR_BAD = 3'd4,
        EV_SUM_BAD = 3'd5,
        EV_END_BAD = 3'd6
    } evt_t;

    typedef struct packed {
        logic              frame_mode;
        logic [BYTE_W-1:0] head_byte;
        logic [BYTE_W-1:0] end_byte;
    } cfg_t;

    typedef struct packed {
        evt_t               event_res;
        logic [BYTE_W-1:0]  payload_byte;
        logic [FIELD_W-1:0] payload_index;
        logic [FIELD_W-1:0] frame_length;
        logic               last_payload;
    } result_t;

endpackage

### src/cld_parser.sv
// Frame parser: phase machine, length/count/sum state and per-byte result logic.
module cld_parser #(
    parameter int unsigned LEN_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic                    mode_wr,
    input  cld_pkg::cfg_t           cfg,
    input  logic [7:0]              rx_byte,
    output cld_pkg::result_t        result
);
    import cld_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HCHK = 3'd1,
        PH_LEN1 = 3'd2,
        PH_LEN2 = 3'd3,
        PH_DATA = 3'd4,
        PH_DCHK = 3'd5,
        PH_END  = 3'd6
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [BYTE_W-1:0]   hdr_chk_reg, hdr_chk_next;
    logic [BYTE_W-1:0]   len_lo_reg,  len_lo_next;
    logic [LEN_BITS-1:0] exp_len_reg, exp_len_next;
    logic [LEN_BITS-1:0] cnt_reg,     cnt_next;
    logic [BYTE_W-1:0]   psum_reg,    psum_next;

    logic [LEN_BITS-1:0] cnt_inc;
    logic [BYTE_W-1:0]   hdr_sum;
    logic [LEN_BITS-1:0] len_full;
    evt_t                ev;
    logic [BYTE_W-1:0]   pbyte;
    logic [LEN_BITS-1:0] pidx;
    logic                last;

    assign cnt_inc  = cnt_reg + LEN_BITS'(1);
    assign hdr_sum  = cfg.head_byte + len_lo_reg + rx_byte;
    assign len_full = LEN_BITS'({rx_byte, len_lo_reg});

    always_comb begin
        phase_next   = phase_reg;
        hdr_chk_next = hdr_chk_reg;
        len_lo_next  = len_lo_reg;
        exp_len_next = exp_len_reg;
        cnt_next     = cnt_reg;
        psum_next    = psum_reg;
        ev           = EV_FRAMING;
        pbyte        = '0;
        pidx         = '0;
        last         = 1'b0;

        if (cfg.frame_mode == MODE_CHECKED) begin
            unique case (phase_reg)
                PH_HCHK: begin
                    hdr_chk_next = rx_byte;
                    phase_next   = PH_LEN1;
                end
                PH_LEN1: begin
                    len_lo_next = rx_byte;
                    phase_next  = PH_LEN2;
                end
                PH_LEN2: begin
                    if (hdr_chk_reg == hdr_sum) begin
                        exp_len_next = len_full;
                        phase_next   = (len_full == '0) ? PH_DCHK : PH_DATA;
                    end else begin
                        ev         = EV_HDR_BAD;
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    ev        = EV_PAYLOAD;
                    pbyte     = rx_byte;
                    pidx      = cnt_reg;
                    psum_next = psum_reg + rx_byte;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == exp_len_reg) begin
                        last       = 1'b1;
                        phase_next = PH_DCHK;
                    end
                end
                PH_DCHK: begin
                    if (psum_reg == rx_byte) begin
                        phase_next = PH_END;
                    end else begin
                        ev         = EV_SUM_BAD;
                        phase_next = PH_HUNT;
                    end
                end
                PH_END: begin
                    ev         = (rx_byte == cfg.end_byte) ? EV_GOOD : EV_END_BAD;
                    phase_next = PH_HUNT;
                end
                default: begin
                    if (rx_byte == cfg.head_byte) begin
                        exp_len_next = '0;
                        cnt_next     = '0;
                        psum_next    = '0;
                        phase_next   = PH_HCHK;
                    end else begin
                        ev         = EV_JUNK;
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end else begin
            unique case (phase_reg)
                PH_HCHK: begin
                    if (rx_byte == SYNC_SECOND) begin
                        phase_next = PH_LEN1;
                    end else begin
                        ev         = EV_JUNK;
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN1: begin
                    exp_len_next = LEN_BITS'(rx_byte);
                    cnt_next     = '0;
                    psum_next    = '0;
                    if (rx_byte == '0) begin
                        ev         = EV_GOOD;
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    ev        = EV_PAYLOAD;
                    pbyte     = rx_byte;
                    pidx      = cnt_reg;
                    psum_next = psum_reg + rx_byte;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == exp_len_reg) begin
                        last       = 1'b1;
                        phase_next = PH_HUNT;
                    end
                end
                default: begin
                    if (rx_byte == SYNC_FIRST) begin
                        exp_len_next = '0;
                        cnt_next     = '0;
                        psum_next    = '0;
                        phase_next   = PH_HCHK;
                    end else begin
                        ev         = EV_JUNK;
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.event_res     = ev;
        result.payload_byte  = pbyte;
        result.payload_index = FIELD_W'(pidx);
        result.frame_length  = FIELD_W'(exp_len_next);
        result.last_payload  = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            hdr_chk_reg <= '0;
            len_lo_reg  <= '0;
            exp_len_reg <= '0;
            cnt_reg     <= '0;
            psum_reg    <= '0;
        end else if (mode_wr) begin
            phase_reg <= PH_HUNT;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            hdr_chk_reg <= hdr_chk_next;
            len_lo_reg  <= len_lo_next;
            exp_len_reg <= exp_len_next;
            cnt_reg     <= cnt_next;
            psum_reg    <= psum_next;
        end
    end

endmodule

### src/checked_length_frame_deframer_top.sv
// Top level of the checked length frame deframer: handshakes, config registers, result register.
// An accepted byte enters the input register; its parsed result enters the result register.
// One byte per cycle while m_ready is high; the phase machine's next-state logic and 8-bit sum are combinational.
// Stalls: input register and result register part the two channels; s_ready only drops
// when both hold an item and m_ready is low.
// Reset (aresetn low, synchronous): both registers empty, parser hunting, counters and sum
// cleared, frame_mode = 1 (fixed FF 55 framing), head_byte = end_byte = 0.
module checked_length_frame_deframer_top #(
    parameter int unsigned LEN_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // byte stream in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,

    // event stream out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_event_res,
    output logic [7:0]                      m_payload_byte,
    output logic [15:0]                     m_payload_index,
    output logic [15:0]                     m_frame_length,
    output logic                            m_last_payload,

    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import cld_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic              out_valid_reg;
    result_t           out_reg;

    // configuration
    cfg_t              cfg_reg;

    logic              advance;
    logic              cfg_wr;
    logic              mode_wr;
    result_t           step_res;

    // The byte in the input register moves on whenever the result register is
    // free or is being emptied by a transfer this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || !out_valid_reg || m_ready;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    // A mode write drops any frame in progress
    assign mode_wr   = cfg_wr && (cfg_index == REG_FRAME_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_res;
        end
    end

    // Index beyond the register list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_mode <= MODE_FIXED;
            cfg_reg.head_byte  <= '0;
            cfg_reg.end_byte   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_FRAME_MODE: cfg_reg.frame_mode <= cfg_data[0];
                REG_HEAD_BYTE:  cfg_reg.head_byte  <= cfg_data;
                REG_END_BYTE:   cfg_reg.end_byte   <= cfg_data;
                default:        ;
            endcase
        end
    end

    cld_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .mode_wr (mode_wr),
        .cfg     (cfg_reg),
        .rx_byte (in_byte_reg),
        .result  (step_res)
    );

    assign m_valid         = out_valid_reg;
    assign m_event_res     = out_reg.event_res;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_index = out_reg.payload_index;
    assign m_frame_length  = out_reg.frame_length;
    assign m_last_payload  = out_reg.last_payload;

endmodule

### sim/cld_event_checker.sv
`timescale 1ns / 1ps
// Event checker for the deframer: predicts each event from the byte transfers and compares.
module cld_event_checker #(
    parameter int unsigned LEN_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [2:0]                      m_event_res,
    input  logic [7:0]                      m_payload_byte,
    input  logic [15:0]                     m_payload_index,
    input  logic [15:0]                     m_frame_length,
    input  logic                            m_last_payload,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    output int                              n_fail,
    output int                              n_pending
);
    import cld_pkg::*;

    localparam logic [FIELD_W-1:0] LEN_MASK = FIELD_W'((32'd1 << LEN_BITS) - 32'd1);

    typedef enum logic [2:0] {
        P_HUNT, P_HCHK, P_LEN1, P_LEN2, P_DATA, P_DCHK, P_END
    } phase_t;

    logic               mode_r;
    logic [7:0]         head_r;
    logic [7:0]         tail_r;
    phase_t             phase;
    logic [7:0]         hdr_chk;
    logic [7:0]         len_lo;
    logic [7:0]         psum;
    logic [15:0]        exp_len;
    logic [15:0]        rcv_cnt;

    result_t            expected_events [$];
    result_t            seen;
    result_t            want;
    int                 mismatches = 0;

    function automatic void open_frame();
        exp_len = '0;
        rcv_cnt = '0;
        psum    = '0;
    endfunction

    // payload byte common to both formats; returns the last-byte flag
    function automatic logic take_payload(input logic [7:0] c, inout result_t r);
        r.event_res     = EV_PAYLOAD;
        r.payload_byte  = c;
        r.payload_index = rcv_cnt;
        psum            = psum + c;
        rcv_cnt         = rcv_cnt + 16'd1;
        r.last_payload  = (rcv_cnt == exp_len);
        return r.last_payload;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] c);
        result_t    r;
        logic [7:0] hsum;
        r = '0;
        r.event_res = EV_FRAMING;
        hsum = head_r + len_lo + c;
        if (mode_r == MODE_CHECKED) begin
            case (phase)
                P_HCHK: begin
                    hdr_chk = c;
                    phase   = P_LEN1;
                end
                P_LEN1: begin
                    len_lo = c;
                    phase  = P_LEN2;
                end
                P_LEN2: begin
                    if (hdr_chk == hsum) begin
                        exp_len = {c, len_lo} & LEN_MASK;
                        phase   = (exp_len == '0) ? P_DCHK : P_DATA;
                    end else begin
                        r.event_res = EV_HDR_BAD;
                        phase       = P_HUNT;
                    end
                end
                P_DATA: begin
                    if (take_payload(c, r))
                        phase = P_DCHK;
                end
                P_DCHK: begin
                    if (psum == c) begin
                        phase = P_END;
                    end else begin
                        r.event_res = EV_SUM_BAD;
                        phase       = P_HUNT;
                    end
                end
                P_END: begin
                    r.event_res = (c == tail_r) ? EV_GOOD : EV_END_BAD;
                    phase       = P_HUNT;
                end
                default: begin
                    phase = P_HUNT;
                    if (c == head_r) begin
                        open_frame();
                        phase = P_HCHK;
                    end else begin
                        r.event_res = EV_JUNK;
                    end
                end
            endcase
        end else begin
            case (phase)
                P_HCHK: begin
                    if (c == SYNC_SECOND) begin
                        phase = P_LEN1;
                    end else begin
                        r.event_res = EV_JUNK;
                        phase       = P_HUNT;
                    end
                end
                P_LEN1: begin
                    open_frame();
                    exp_len = {8'd0, c} & LEN_MASK;
                    if (exp_len == '0) begin
                        r.event_res = EV_GOOD;
                        phase       = P_HUNT;
                    end else begin
                        phase = P_DATA;
                    end
                end
                P_DATA: begin
                    if (take_payload(c, r))
                        phase = P_HUNT;
                end
                default: begin
                    phase = P_HUNT;
                    if (c == SYNC_FIRST) begin
                        open_frame();
                        phase = P_HCHK;
                    end else begin
                        r.event_res = EV_JUNK;
                    end
                end
            endcase
        end
        r.frame_length = exp_len;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_r  = MODE_FIXED;
            head_r  = '0;
            tail_r  = '0;
            phase   = P_HUNT;
            hdr_chk = '0;
            len_lo  = '0;
            exp_len = '0;
            rcv_cnt = '0;
            psum    = '0;
            expected_events.delete();
            n_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_MODE: begin
                        mode_r = cfg_data[0];
                        phase  = P_HUNT;
                    end
                    REG_HEAD_BYTE: head_r = cfg_data;
                    REG_END_BYTE:  tail_r = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_events.push_back(parse_byte(s_rx_byte));
            if (m_valid && m_ready) begin
                seen = {m_event_res, m_payload_byte, m_payload_index,
                        m_frame_length, m_last_payload};
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: unexpected event ev=%0d byte=%02h idx=%0d len=%0d last=%0b",
                                 $realtime, seen.event_res, seen.payload_byte,
                                 seen.payload_index, seen.frame_length, seen.last_payload);
                end else begin
                    want = expected_events.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t: expected ev=%0d byte=%02h idx=%0d len=%0d last=%0b",
                                     $realtime, want.event_res, want.payload_byte,
                                     want.payload_index, want.frame_length, want.last_payload);
                            $display("%t:      got ev=%0d byte=%02h idx=%0d len=%0d last=%0b",
                                     $realtime, seen.event_res, seen.payload_byte,
                                     seen.payload_index, seen.frame_length, seen.last_payload);
                        end
                    end
                end
            end
            n_fail    <= mismatches;
            n_pending <= expected_events.size();
        end
    end

endmodule

### sim/checked_length_frame_deframer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the deframer: clock, reset, byte and config stimulus, and the verdict.
module checked_length_frame_deframer_top_tb;
    import cld_pkg::*;

    localparam int unsigned LEN_BITS = 16;
    // index 3 lies beyond the register list; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SEG_ITEMS    = 180;   // bytes per random segment; the last frame runs over
    localparam int DRAIN_CYCLES = 8;     // byte passes input, then result register; pad a little

    // what goes wrong with a generated frame, if anything
    typedef enum {
        FAULT_NONE, FAULT_HDR, FAULT_SUM, FAULT_END, FAULT_SYNC, FAULT_NOISE
    } fault_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic [7:0]             s_rx_byte = '0;
    logic                   m_ready   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_FRAME_MODE;
    logic [7:0]             cfg_data  = '0;

    logic                   s_ready;
    logic                   m_valid;
    logic [2:0]             m_event_res;
    logic [7:0]             m_payload_byte;
    logic [15:0]            m_payload_index;
    logic [15:0]            m_frame_length;
    logic                   m_last_payload;
    logic                   cfg_ready;

    int                     n_fail;
    int                     n_pending;

    // idle rates in percent, changed per phase
    int                     send_idle  = 8;
    int                     recv_idle  = 51;
    int                     bytes_sent = 0;
    // head and end bytes currently programmed, needed to build checked frames
    logic [7:0]             head_cur   = '0;
    logic [7:0]             tail_cur   = '0;

    checked_length_frame_deframer_top #(.LEN_BITS(LEN_BITS)) DUT (.*);

    cld_event_checker #(.LEN_BITS(LEN_BITS)) event_chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure: m_ready rerolled every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // One byte transfer. Random idle cycles go in front of it; once valid is up it
    // stays up with the same byte until the transfer happens.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Register write; valid drops for one cycle afterwards so that back-to-back
    // writes never lower and raise it in the same step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending and wait until every predicted event has come back.
    // The first edge lets the checker count a transfer made at this very edge.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly short payloads, some medium, now and then up to the cap.
    function automatic int pick_len(input int len_cap);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 6);
        else if (r < 85)
            return $urandom_range(0, 40);
        else if (r < 97)
            return $urandom_range(0, len_cap);
        return len_cap;
    endfunction

    // Checked framing: head, header check, length lo/hi, payload, payload sum, end.
    // A header fault ends the frame after the length bytes; other faults end it at the bad byte.
    task automatic send_checked_frame(input logic [15:0] len, input fault_t fault);
        logic [7:0] chk;
        logic [7:0] csum;
        logic [7:0] pb;
        chk  = head_cur + len[7:0] + len[15:8];
        csum = '0;
        if (fault == FAULT_HDR)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(head_cur);
        send_byte(chk);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (fault == FAULT_HDR)
            return;
        for (int i = 0; i < int'(len); i++) begin
            pb   = 8'($urandom);
            csum = csum + pb;
            send_byte(pb);
        end
        if (fault == FAULT_SUM) begin
            send_byte(csum ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(csum);
        if (fault == FAULT_END)
            send_byte(tail_cur ^ 8'($urandom_range(1, 255)));
        else
            send_byte(tail_cur);
    endtask

    // Fixed framing: FF 55, one length byte, payload. A sync fault breaks the 55.
    task automatic send_fixed_frame(input logic [7:0] len, input fault_t fault);
        send_byte(SYNC_FIRST);
        if (fault == FAULT_SYNC) begin
            send_byte(SYNC_SECOND ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(SYNC_SECOND);
        send_byte(len);
        for (int i = 0; i < int'(len); i++)
            send_byte(8'($urandom));
    endtask

    // Stray bytes between frames; they may well start a frame by chance.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
    endtask

    // One setting of the registers followed by a run of random frames.
    task automatic run_segment(input logic mode, input logic [7:0] head,
                               input logic [7:0] tail, input int n_items);
        int     r;
        fault_t fault;
        wait_drained();
        cfg_write(REG_HEAD_BYTE, head);
        cfg_write(REG_END_BYTE, tail);
        cfg_write(REG_FRAME_MODE, {7'd0, mode});
        head_cur   = head;
        tail_cur   = tail;
        bytes_sent = 0;
        while (bytes_sent < n_items) begin
            r = $urandom_range(0, 99);
            if (mode == MODE_CHECKED) begin
                if (r < 65)      fault = FAULT_NONE;
                else if (r < 73) fault = FAULT_HDR;
                else if (r < 81) fault = FAULT_SUM;
                else if (r < 89) fault = FAULT_END;
                else             fault = FAULT_NOISE;
                if (fault == FAULT_NOISE)
                    send_noise();
                else
                    send_checked_frame(16'(pick_len(300)), fault);
            end else begin
                if (r < 75)      fault = FAULT_NONE;
                else if (r < 85) fault = FAULT_SYNC;
                else             fault = FAULT_NOISE;
                if (fault == FAULT_NOISE)
                    send_noise();
                else
                    send_fixed_frame(8'(pick_len(255)), fault);
            end
        end
    endtask

    initial begin
        // Fixed framing straight out of reset: junk, zero length, a two-byte payload
        // holding FF and 00, then a frame left open for the mode write to drop.
        logic [7:0] fixed_seq [13] = '{
            8'h00,
            SYNC_FIRST, SYNC_SECOND, 8'h00,
            SYNC_FIRST, SYNC_SECOND, 8'h02, 8'hFF, 8'h00,
            SYNC_FIRST, SYNC_SECOND, 8'h05, 8'h00
        };
        // Checked framing with head A5 / end 5A: a good two-byte frame whose bytes
        // sum to FF, then a zero-length frame whose sum byte is 00.
        logic [7:0] checked_seq [14] = '{
            8'hA5, 8'hA7, 8'h02, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h5A,
            8'hA5, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h5A
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (fixed_seq[i]) send_byte(fixed_seq[i]);
        wait_drained();
        cfg_write(REG_SPARE, 8'hFF);
        cfg_write(REG_HEAD_BYTE, 8'hA5);
        cfg_write(REG_END_BYTE, 8'h5A);
        cfg_write(REG_FRAME_MODE, {7'd0, MODE_CHECKED});
        head_cur = 8'hA5;
        tail_cur = 8'h5A;
        foreach (checked_seq[i]) send_byte(checked_seq[i]);

        // sender mostly busy, receiver stalling about half the time
        run_segment(MODE_FIXED, 8'h00, 8'hFF, SEG_ITEMS);
        run_segment(MODE_CHECKED, 8'h00, 8'hFF, SEG_ITEMS);

        // roles swapped
        send_idle = 51;
        recv_idle = 8;
        run_segment(MODE_FIXED, 8'hFF, 8'h00, SEG_ITEMS);
        run_segment(MODE_CHECKED, 8'hFF, 8'h00, SEG_ITEMS);

        // full rate, random head/end
        send_idle = 0;
        recv_idle = 0;
        run_segment(MODE_FIXED, 8'($urandom), 8'($urandom), SEG_ITEMS);
        run_segment(MODE_CHECKED, 8'($urandom), 8'($urandom), SEG_ITEMS);

        wait_drained();
        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: the slowest correct run is well under a tenth of this.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
